[rtl/core/erpm_pkg.sv]
// Encoder rpm estimator: shared types and constants.
// No dependencies; compiled first.
`default_nettype none

package erpm_pkg;

	localparam int unsigned COUNT_W   = 16;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned SPEED_W   = 24;
	localparam int unsigned ALPHA_W   = 9;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned PROD_W    = 32;

	localparam logic [15:0] RPM_SCALE   = 16'd60000;
	localparam logic [15:0] INTERVAL_RST = 16'd100;
	localparam logic [15:0] RESYNC_RST  = 16'd800;
	localparam logic [15:0] CPR_RST     = 16'd1792;
	localparam logic [8:0]  ALPHA_RST   = 9'd77;
	localparam logic [8:0]  ALPHA_ONE   = 9'd256;

	localparam logic signed [SPEED_W-1:0] SPD_MAX = 24'sh7FFFFF;
	localparam logic signed [SPEED_W-1:0] SPD_MIN = 24'sh800000;

	typedef enum logic [1:0] {
		CFG_INTERVAL = 2'd0,
		CFG_RESYNC   = 2'd1,
		CFG_CPR      = 2'd2,
		CFG_ALPHA    = 2'd3
	} erpm_cfg_idx_t;

	typedef enum logic [1:0] {
		WS_EARLY   = 2'd0,
		WS_RESYNC  = 2'd1,
		WS_UPDATE  = 2'd2,
		WS_RESTART = 2'd3
	} erpm_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_DIV,
		S_EMA_MUL,
		S_EMA_ADD,
		S_OUT
	} erpm_state_t;

	typedef struct packed {
		logic [TIME_W-1:0]  now_ms;
		logic [COUNT_W-1:0] left_count;
		logic [COUNT_W-1:0] right_count;
		logic               restart;
	} erpm_sample_t;

	typedef struct packed {
		logic [1:0]                window_status;
		logic signed [SPEED_W-1:0] left_speed;
		logic signed [SPEED_W-1:0] right_speed;
	} erpm_result_t;

	typedef struct packed {
		logic load_in;
		logic decide;
		logic div_step;
		logic ema_mul;
		logic ema_commit;
		logic out_load;
	} erpm_cmd_t;

	typedef struct packed {
		logic restart;
		logic early;
		logic resync;
		logic div_done;
	} erpm_stat_t;

endpackage

`default_nettype wire

[rtl/core/erpm_stream_if.sv]
// Valid/ready stream channel carrying one payload beat.
// Payload type supplied by the instantiating level.
`default_nettype none

interface erpm_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/erpm_ctrl.sv]
// Sequencing state machine for the rpm estimator.
// Depends on erpm_pkg; drives erpm_datapath through erpm_cmd_t.
`default_nettype none

module erpm_ctrl
	import erpm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire erpm_stat_t stat,
	output erpm_cmd_t       cmd
);

	erpm_state_t state_q, state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				if (stat.restart || stat.early || stat.resync)
					state_d = S_OUT;
				else
					state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done)
					state_d = S_EMA_MUL;
			end
			S_EMA_MUL: begin
				cmd.ema_mul = 1'b1;
				state_d     = S_EMA_ADD;
			end
			S_EMA_ADD: begin
				cmd.ema_commit = 1'b1;
				state_d        = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[rtl/core/erpm_datapath.sv]
// Datapath: config registers, baseline and smoothed state, scaling multipliers,
// two-lane restoring divider and EMA. Depends on erpm_pkg.
`default_nettype none

module erpm_datapath
	import erpm_pkg::*;
#(
	parameter int unsigned SPEED_FRAC_BITS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data,
	input  wire erpm_sample_t       in_data,
	input  wire erpm_cmd_t          cmd,
	output erpm_stat_t              stat,
	output erpm_result_t            out_data
);

	localparam int unsigned NUM_W = PROD_W + SPEED_FRAC_BITS;
	localparam int unsigned CNT_W = $clog2(NUM_W);
	localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(24'h7FFFFF);
	localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(25'h0800000);

	logic [15:0]        interval_q, resync_q, cpr_q;
	logic [ALPHA_W-1:0] alpha_q;

	erpm_sample_t       in_q;
	logic [COUNT_W-1:0] base_left_q, base_right_q;
	logic [TIME_W-1:0]  base_time_q;
	logic signed [SPEED_W-1:0] smooth_left_q, smooth_right_q;
	erpm_status_t       status_q;

	logic [NUM_W-1:0]   num_l_q, num_r_q;
	logic [PROD_W-1:0]  rem_l_q, rem_r_q;
	logic [PROD_W-1:0]  den_q;
	logic               neg_l_q, neg_r_q;
	logic [CNT_W-1:0]   cnt_q;

	logic signed [33:0] pa_l_q, pb_l_q, pa_r_q, pb_r_q;

	erpm_result_t       out_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RST;
			resync_q   <= RESYNC_RST;
			cpr_q      <= CPR_RST;
			alpha_q    <= ALPHA_RST;
		end else if (cfg_wr_en) begin
			unique case (erpm_cfg_idx_t'(cfg_index))
				CFG_INTERVAL: interval_q <= cfg_data;
				CFG_RESYNC:   resync_q   <= cfg_data;
				CFG_CPR:      cpr_q      <= cfg_data;
				CFG_ALPHA:    alpha_q    <= cfg_data[ALPHA_W-1:0];
				default:      ;
			endcase
		end
	end

	// window classification
	logic [TIME_W-1:0]  dt;
	logic [15:0]        ivl, cpr_c;
	logic [COUNT_W-1:0] d_l, d_r, mag_l, mag_r;

	always_comb begin
		dt    = in_q.now_ms - base_time_q;
		ivl   = (interval_q == 16'd0) ? 16'd1 : interval_q;
		cpr_c = (cpr_q == 16'd0) ? 16'd1 : cpr_q;
		d_l   = in_q.left_count - base_left_q;
		d_r   = in_q.right_count - base_right_q;
		mag_l = d_l[15] ? COUNT_W'(-d_l) : d_l;
		mag_r = d_r[15] ? COUNT_W'(-d_r) : d_r;
		stat.restart  = in_q.restart;
		stat.early    = dt < {16'd0, ivl};
		stat.resync   = dt > {16'd0, resync_q};
		stat.div_done = cnt_q == CNT_W'(NUM_W - 1);
	end

	// divider step, one quotient bit per lane per cycle
	logic [PROD_W:0] sh_l, sh_r, den_x;
	logic            ge_l, ge_r;

	always_comb begin
		den_x = {1'b0, den_q};
		sh_l  = {rem_l_q, num_l_q[NUM_W-1]};
		sh_r  = {rem_r_q, num_r_q[NUM_W-1]};
		ge_l  = sh_l >= den_x;
		ge_r  = sh_r >= den_x;
	end

	// raw rpm saturation and alpha clamp
	logic signed [SPEED_W-1:0] raw_l, raw_r;
	logic [ALPHA_W-1:0]        a_c, a_inv;

	always_comb begin
		if (neg_l_q)
			raw_l = (num_l_q > NEG_LIM) ? SPD_MIN : -SPEED_W'(num_l_q);
		else
			raw_l = (num_l_q > POS_LIM) ? SPD_MAX : SPEED_W'(num_l_q);
		if (neg_r_q)
			raw_r = (num_r_q > NEG_LIM) ? SPD_MIN : -SPEED_W'(num_r_q);
		else
			raw_r = (num_r_q > POS_LIM) ? SPD_MAX : SPEED_W'(num_r_q);
		a_c   = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
		a_inv = ALPHA_ONE - a_c;
	end

	// EMA sum, floor shift, saturate
	logic signed [34:0] sum_l, sum_r, sh8_l, sh8_r;
	logic signed [SPEED_W-1:0] ema_l, ema_r;

	always_comb begin
		sum_l = 35'(pa_l_q) + 35'(pb_l_q);
		sum_r = 35'(pa_r_q) + 35'(pb_r_q);
		sh8_l = sum_l >>> 8;
		sh8_r = sum_r >>> 8;
		if (sh8_l > 35'(SPD_MAX))
			ema_l = SPD_MAX;
		else if (sh8_l < 35'(SPD_MIN))
			ema_l = SPD_MIN;
		else
			ema_l = SPEED_W'(sh8_l);
		if (sh8_r > 35'(SPD_MAX))
			ema_r = SPD_MAX;
		else if (sh8_r < 35'(SPD_MIN))
			ema_r = SPD_MIN;
		else
			ema_r = SPEED_W'(sh8_r);
	end

	// state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_left_q    <= '0;
			base_right_q   <= '0;
			base_time_q    <= '0;
			smooth_left_q  <= '0;
			smooth_right_q <= '0;
			cnt_q          <= '0;
		end else begin
			if ((cmd.decide && (stat.restart || (!stat.early && stat.resync)))
					|| cmd.ema_commit) begin
				base_left_q  <= in_q.left_count;
				base_right_q <= in_q.right_count;
				base_time_q  <= in_q.now_ms;
			end
			if (cmd.ema_commit) begin
				smooth_left_q  <= ema_l;
				smooth_right_q <= ema_r;
			end
			if (cmd.decide)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in)
			in_q <= in_data;
		if (cmd.decide) begin
			if (stat.restart)
				status_q <= WS_RESTART;
			else if (stat.early)
				status_q <= WS_EARLY;
			else if (stat.resync)
				status_q <= WS_RESYNC;
			else
				status_q <= WS_UPDATE;
			num_l_q <= {PROD_W'(mag_l) * PROD_W'(RPM_SCALE), SPEED_FRAC_BITS'(0)};
			num_r_q <= {PROD_W'(mag_r) * PROD_W'(RPM_SCALE), SPEED_FRAC_BITS'(0)};
			den_q   <= PROD_W'(cpr_c) * PROD_W'(dt[15:0]);
			rem_l_q <= '0;
			rem_r_q <= '0;
			neg_l_q <= d_l[15];
			neg_r_q <= d_r[15];
		end else if (cmd.div_step) begin
			rem_l_q <= ge_l ? PROD_W'(sh_l - den_x) : sh_l[PROD_W-1:0];
			rem_r_q <= ge_r ? PROD_W'(sh_r - den_x) : sh_r[PROD_W-1:0];
			num_l_q <= {num_l_q[NUM_W-2:0], ge_l};
			num_r_q <= {num_r_q[NUM_W-2:0], ge_r};
		end
		if (cmd.ema_mul) begin
			pa_l_q <= $signed({1'b0, a_c}) * raw_l;
			pb_l_q <= $signed({1'b0, a_inv}) * smooth_left_q;
			pa_r_q <= $signed({1'b0, a_c}) * raw_r;
			pb_r_q <= $signed({1'b0, a_inv}) * smooth_right_q;
		end
		if (cmd.out_load) begin
			out_q.window_status <= status_q;
			out_q.left_speed    <= smooth_left_q;
			out_q.right_speed   <= smooth_right_q;
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

[rtl/core/encoder_rpm_estimator_core.sv]
// Two-channel encoder rpm estimator with exponential smoothing.
// Each accepted sample is first classified; a sample that updates the speeds then
// passes through the shared restoring divider (one quotient bit per cycle, both
// channels side by side) and the EMA multiply and add steps, while other samples
// go straight to the output. One sample is processed at a time; the result beat
// is held in an output register so the next sample can be taken while it waits.
// Depends on erpm_pkg, erpm_stream_if, erpm_ctrl, erpm_datapath.
`default_nettype none

module encoder_rpm_estimator_core
	import erpm_pkg::*;
#(
	parameter int unsigned SPEED_FRAC_BITS = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	erpm_stream_if.sink           sample,
	erpm_stream_if.source         result
);

	erpm_cmd_t    cmd;
	erpm_stat_t   stat;
	erpm_result_t out_data;

	erpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	erpm_datapath #(
		.SPEED_FRAC_BITS (SPEED_FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (sample.payload),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);

	assign result.payload = out_data;

endmodule

`default_nettype wire
